// ----- hdl/rdf_pkg.sv -----
// Package for the radar despeckle filter.
// Holds default sizes, register constants and state encodings.
// No dependencies.
package rdf_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_GATES      = 4096;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_MULT_FRAC_BITS = 8;

    // Threshold multiplier register.
    localparam int          MULT_BITS  = 16;
    localparam logic [15:0] MULT_RESET = 16'd512;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Front sequencer states.
    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_UPD   = 4'b0010,
        F_PUSH0 = 4'b0100,
        F_PUSH1 = 4'b1000
    } front_state_t;

    // Back sequencer states.
    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_SORT1 = 7'b0000010,
        B_SORT2 = 7'b0000100,
        B_TEST  = 7'b0001000,
        B_SQ    = 7'b0010000,
        B_MUL   = 7'b0100000,
        B_CMP   = 7'b1000000
    } back_state_t;

    // Output register status shared by the back end and the top level.
    typedef struct packed {
        logic busy;
        logic free;
    } out_stat_t;

endpackage

// ----- hdl/radar_despeckle_filter.sv -----
// Top level of the radar despeckle filter.
// Depends on rdf_pkg, rdf_front, rdf_queue and rdf_back.
//
// A sample stream of the newest pulse enters on s_axis-style ports, one range gate per
// transfer, and filtered samples of the middle pulse leave on the m_ ports. Output starts
// once two pulses are complete; a gate p >= 1 yields gate p-1, and the last gate also
// yields the last middle gate with tlast. An input transfer passes through the front end
// as store read, window update and two job slots. A passthrough gate goes straight to
// the output register; an inner gate runs two sort steps and the median test and, when it
// is above the median, the single shared squarer stepping over seven distances, the
// multiply and the compare. A four-entry job queue lets the two ends stall independently.
// Write variance_multiplier (8 fraction bits) only while no results are pending.
module radar_despeckle_filter #(
    parameter int MAX_GATES      = rdf_pkg::DEF_MAX_GATES,
    parameter int SAMPLE_BITS    = rdf_pkg::DEF_SAMPLE_BITS,
    parameter int MULT_FRAC_BITS = rdf_pkg::DEF_MULT_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel: variance_multiplier.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rdf_pkg::MULT_BITS-1:0]        cfg_data,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample_in
    input  logic                                 s_tlast,   // last_gate
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // sample_out
    output logic [0:0]                           m_tuser,   // replaced
    output logic                                 m_tlast    // end_of_pulse
);
    import rdf_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int DW = ((S + 7) / 8) * 8;
    localparam int JW = 7 * S + 2;

    logic [MULT_BITS-1:0] mult_reg;
    logic                 q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [JW-1:0]        q_in_data, q_out_data;
    logic [S-1:0]         sample_out;
    out_stat_t            ostat;

    // Threshold register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= MULT_RESET;
        end else if (cfg_valid) begin
            mult_reg <= cfg_data;
        end
    end

    rdf_front #(
        .MAX_GATES   (MAX_GATES),
        .SAMPLE_BITS (S),
        .JOB_BITS    (JW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[S-1:0]),
        .in_last    (s_tlast),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data)
    );

    rdf_queue #(
        .WIDTH (JW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    rdf_back #(
        .SAMPLE_BITS    (S),
        .MULT_FRAC_BITS (MULT_FRAC_BITS),
        .JOB_BITS       (JW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .multiplier   (mult_reg),
        .job_valid    (q_out_valid),
        .job_ready    (q_out_ready),
        .job_data     (q_out_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_sample   (sample_out),
        .out_replaced (m_tuser[0]),
        .out_eop      (m_tlast),
        .out_stat     (ostat)
    );

    assign m_tdata = DW'(sample_out);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front took two samples in a row");
    a_stat_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ostat.busy == m_tvalid)
        else $error("output status out of step with valid");

endmodule

// ----- hdl/rdf_front.sv -----
// Front end of the despeckle filter: line stores, sliding windows and job forming.
// Depends on rdf_pkg. Each accepted sample produces zero, one or two queue jobs.
module rdf_front #(
    parameter int MAX_GATES   = rdf_pkg::DEF_MAX_GATES,
    parameter int SAMPLE_BITS = rdf_pkg::DEF_SAMPLE_BITS,
    parameter int JOB_BITS    = 7 * rdf_pkg::DEF_SAMPLE_BITS + 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [JOB_BITS-1:0]           push_data
);
    import rdf_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int GW = $clog2(MAX_GATES);
    localparam logic [GW-1:0] GATE_TOP = GW'(MAX_GATES - 1);

    front_state_t fst_reg, fst_next;

    logic [S-1:0]  x_reg;
    logic          last_reg;
    logic [GW-1:0] gpos_reg;
    logic [1:0]    seen_reg;
    logic [S-1:0]  newer_reg [3];
    logic [S-1:0]  older_reg [3];
    logic [S-1:0]  mid_reg   [2];
    logic [S-1:0]  mid_rd_reg, old_rd_reg;
    logic          j0_need_reg, j1_need_reg;
    logic [JOB_BITS-1:0] j0_reg, j1_reg;

    // Line stores; contents are undefined until written.
    logic [S-1:0] mid_mem [MAX_GATES];
    logic [S-1:0] old_mem [MAX_GATES];

    logic accept;
    logic ready_stage;

    assign accept   = in_valid && in_ready;
    assign in_ready = (fst_reg == F_IDLE);

    // Store access: read at accept, write back in the next cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_rd_reg <= mid_mem[gpos_reg];
            old_rd_reg <= old_mem[gpos_reg];
            x_reg      <= in_sample;
            last_reg   <= in_last;
        end
        if (fst_reg == F_UPD) begin
            old_mem[gpos_reg] <= mid_rd_reg;
            mid_mem[gpos_reg] <= x_reg;
        end
    end

    // Window update and job forming.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gpos_reg    <= '0;
            seen_reg    <= '0;
            j0_need_reg <= 1'b0;
            j1_need_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                newer_reg[i] <= '0;
                older_reg[i] <= '0;
            end
            mid_reg[0] <= '0;
            mid_reg[1] <= '0;
        end else if (fst_reg == F_UPD) begin
            older_reg[0] <= older_reg[1];
            older_reg[1] <= older_reg[2];
            older_reg[2] <= old_rd_reg;
            newer_reg[0] <= newer_reg[1];
            newer_reg[1] <= newer_reg[2];
            newer_reg[2] <= x_reg;
            mid_reg[0]   <= mid_reg[1];
            mid_reg[1]   <= mid_rd_reg;
            j0_need_reg  <= (seen_reg == 2'd2) && (gpos_reg != '0);
            j1_need_reg  <= (seen_reg == 2'd2) && last_reg;
            // First job: the gate before this one, filtered at inner gates.
            j0_reg <= {1'b0, (gpos_reg > GW'(1)),
                       newer_reg[2], x_reg, newer_reg[1],
                       older_reg[2], old_rd_reg, older_reg[1],
                       mid_reg[1]};
            // Second job: the last gate passes through.
            j1_reg <= {1'b1, 1'b0, {(6 * S){1'b0}}, mid_rd_reg};
            priority if (last_reg) begin
                gpos_reg <= '0;
                if (seen_reg != 2'd2) seen_reg <= seen_reg + 2'd1;
            end else if (gpos_reg != GATE_TOP) begin
                gpos_reg <= gpos_reg + GW'(1);
            end
        end
    end

    // Sequencer.
    always_comb begin
        fst_next    = fst_reg;
        push_valid  = 1'b0;
        push_data   = j0_reg;
        ready_stage = push_ready;
        unique case (fst_reg)
            F_IDLE:  if (accept) fst_next = F_UPD;
            F_UPD:   fst_next = F_PUSH0;
            F_PUSH0: begin
                push_valid = j0_need_reg;
                if (!j0_need_reg || ready_stage) fst_next = F_PUSH1;
            end
            F_PUSH1: begin
                push_valid = j1_need_reg;
                push_data  = j1_reg;
                if (!j1_need_reg || ready_stage) fst_next = F_IDLE;
            end
            default: fst_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fst_reg <= F_IDLE;
        end else begin
            fst_reg <= fst_next;
        end
    end

    // The front never takes a sample while jobs of the previous one are pending.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (fst_reg == F_PUSH0 || fst_reg == F_PUSH1) |-> !in_ready)
        else $error("front accepted a sample while pushing jobs");
    a_upd_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> fst_reg == F_UPD)
        else $error("front did not update after a transfer");
    a_seen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg != 2'd3)
        else $error("pulse count passed saturation");

endmodule

// ----- hdl/rdf_queue.sv -----
// Short job queue that decouples the front and back ends of the filter.
// Depends on rdf_pkg for the depth.
module rdf_queue #(
    parameter int WIDTH = 7 * rdf_pkg::DEF_SAMPLE_BITS + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import rdf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wptr_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + AW'(1);
            if (pop)  rptr_reg <= rptr_reg + AW'(1);
            if (push && !pop)      count_reg <= count_reg + CW'(1);
            else if (pop && !push) count_reg <= count_reg - CW'(1);
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill count out of range");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count missed a transfer");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// ----- hdl/rdf_back.sv -----
// Back end of the despeckle filter: median, variance test and output register.
// Depends on rdf_pkg. One shared squarer is stepped over the seven distances.
module rdf_back #(
    parameter int SAMPLE_BITS    = rdf_pkg::DEF_SAMPLE_BITS,
    parameter int MULT_FRAC_BITS = rdf_pkg::DEF_MULT_FRAC_BITS,
    parameter int JOB_BITS       = 7 * rdf_pkg::DEF_SAMPLE_BITS + 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rdf_pkg::MULT_BITS-1:0]   multiplier,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  logic [JOB_BITS-1:0]             job_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [SAMPLE_BITS-1:0]          out_sample,
    output logic                            out_replaced,
    output logic                            out_eop,
    output rdf_pkg::out_stat_t              out_stat
);
    import rdf_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int QW = 2 * S + 2;          // one squared distance
    localparam int VW = 2 * S + 5;          // sum of six squares
    localparam int CW = 2 * S + 5 + MULT_BITS;

    back_state_t bst_reg, bst_next;

    logic signed [S-1:0] tap_reg  [7];      // six neighbors, then the center
    logic signed [S-1:0] sort_reg [6];
    logic signed [S:0]   m2_reg;
    logic [2:0]          cnt_reg;
    logic [QW-1:0]       sq_reg, dsq_reg;
    logic [VW-1:0]       var_reg;
    logic [CW-1:0]       rhs_reg;

    logic                out_valid_reg, out_rep_reg, out_eop_reg;
    logic [S-1:0]        out_data_reg;

    logic                out_free, pop, pop_pass;
    logic                res_load;
    logic [S-1:0]        res_data;
    logic                res_rep;

    logic signed [S-1:0] l1 [6];
    logic signed [S-1:0] l2 [6];
    logic signed [S-1:0] l3 [6];
    logic signed [S-1:0] l4 [6];
    logic signed [S-1:0] l5 [6];
    logic signed [S+1:0] diff;
    logic [S+1:0]        diff_abs;
    logic [S:0]          mag;
    logic signed [S:0]   fl;
    logic signed [S:0]   center2;
    logic [CW-1:0]       lhs;

    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_sample   = out_data_reg;
    assign out_replaced = out_rep_reg;
    assign out_eop      = out_eop_reg;
    assign out_stat     = '{busy: out_valid_reg, free: out_free};

    // Jobs are taken only when idle; a passthrough job also needs the output free.
    assign job_ready = (bst_reg == B_IDLE) && (job_data[7*S] || out_free);
    assign pop       = job_valid && job_ready;
    assign pop_pass  = pop && !job_data[7*S];

    // Sorting network on six inputs, first three layers.
    always_comb begin
        for (int i = 0; i < 6; i++) l1[i] = tap_reg[i];
        l1[0] = (tap_reg[0] > tap_reg[5]) ? tap_reg[5] : tap_reg[0];
        l1[5] = (tap_reg[0] > tap_reg[5]) ? tap_reg[0] : tap_reg[5];
        l1[1] = (tap_reg[1] > tap_reg[3]) ? tap_reg[3] : tap_reg[1];
        l1[3] = (tap_reg[1] > tap_reg[3]) ? tap_reg[1] : tap_reg[3];
        l1[2] = (tap_reg[2] > tap_reg[4]) ? tap_reg[4] : tap_reg[2];
        l1[4] = (tap_reg[2] > tap_reg[4]) ? tap_reg[2] : tap_reg[4];
        for (int i = 0; i < 6; i++) l2[i] = l1[i];
        l2[1] = (l1[1] > l1[2]) ? l1[2] : l1[1];
        l2[2] = (l1[1] > l1[2]) ? l1[1] : l1[2];
        l2[3] = (l1[3] > l1[4]) ? l1[4] : l1[3];
        l2[4] = (l1[3] > l1[4]) ? l1[3] : l1[4];
        for (int i = 0; i < 6; i++) l3[i] = l2[i];
        l3[0] = (l2[0] > l2[3]) ? l2[3] : l2[0];
        l3[3] = (l2[0] > l2[3]) ? l2[0] : l2[3];
        l3[2] = (l2[2] > l2[5]) ? l2[5] : l2[2];
        l3[5] = (l2[2] > l2[5]) ? l2[2] : l2[5];
    end

    // Last two layers of the network.
    always_comb begin
        for (int i = 0; i < 6; i++) l4[i] = sort_reg[i];
        l4[0] = (sort_reg[0] > sort_reg[1]) ? sort_reg[1] : sort_reg[0];
        l4[1] = (sort_reg[0] > sort_reg[1]) ? sort_reg[0] : sort_reg[1];
        l4[2] = (sort_reg[2] > sort_reg[3]) ? sort_reg[3] : sort_reg[2];
        l4[3] = (sort_reg[2] > sort_reg[3]) ? sort_reg[2] : sort_reg[3];
        l4[4] = (sort_reg[4] > sort_reg[5]) ? sort_reg[5] : sort_reg[4];
        l4[5] = (sort_reg[4] > sort_reg[5]) ? sort_reg[4] : sort_reg[5];
        for (int i = 0; i < 6; i++) l5[i] = l4[i];
        l5[1] = (l4[1] > l4[2]) ? l4[2] : l4[1];
        l5[2] = (l4[1] > l4[2]) ? l4[1] : l4[2];
        l5[3] = (l4[3] > l4[4]) ? l4[4] : l4[3];
        l5[4] = (l4[3] > l4[4]) ? l4[3] : l4[4];
    end

    // Doubled distance of the selected sample from the median, and its magnitude.
    always_comb begin
        diff     = {tap_reg[cnt_reg][S-1], tap_reg[cnt_reg], 1'b0} - {m2_reg[S], m2_reg};
        diff_abs = diff[S+1] ? (S+2)'(-diff) : diff;
        mag      = diff_abs[S:0];
    end

    // Median rounded half to even, and the doubled center.
    always_comb begin
        fl = m2_reg >>> 1;
        if (m2_reg[0] && fl[0]) fl = fl + (S+1)'(1);
        center2 = {tap_reg[6], 1'b0};
        lhs     = CW'(dsq_reg) << MULT_FRAC_BITS;
    end

    // Sequencer and result selection.
    always_comb begin
        bst_next = bst_reg;
        res_load = 1'b0;
        res_data = tap_reg[6];
        res_rep  = 1'b0;
        unique case (bst_reg)
            B_IDLE:  if (pop && job_data[7*S]) bst_next = B_SORT1;
            B_SORT1: bst_next = B_SORT2;
            B_SORT2: bst_next = B_TEST;
            B_TEST: begin
                if (center2 > m2_reg) begin
                    bst_next = B_SQ;
                end else if (out_free) begin
                    res_load = 1'b1;
                    bst_next = B_IDLE;
                end
            end
            B_SQ:    if (cnt_reg == 3'd7) bst_next = B_MUL;
            B_MUL:   bst_next = B_CMP;
            B_CMP: begin
                if (out_free) begin
                    res_load = 1'b1;
                    res_rep  = (lhs > rhs_reg);
                    if (lhs > rhs_reg) res_data = fl[S-1:0];
                    bst_next = B_IDLE;
                end
            end
            default: bst_next = B_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < 6; i++) tap_reg[i] <= job_data[S*(i+1) +: S];
            tap_reg[6] <= job_data[S-1:0];
        end
        if (bst_reg == B_SORT1) begin
            for (int i = 0; i < 6; i++) sort_reg[i] <= l3[i];
        end
        if (bst_reg == B_SORT2) begin
            m2_reg <= {l5[2][S-1], l5[2]} + {l5[3][S-1], l5[3]};
        end
        // Square one distance a cycle; accumulate the previous one.
        if (bst_reg == B_TEST) begin
            cnt_reg <= 3'd0;
            var_reg <= '0;
        end
        if (bst_reg == B_SQ) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg != 3'd7) sq_reg <= mag * mag;
            if (cnt_reg != 3'd0) begin
                if (cnt_reg == 3'd7) dsq_reg <= sq_reg;
                else                 var_reg <= var_reg + VW'(sq_reg);
            end
        end
        if (bst_reg == B_MUL) begin
            rhs_reg <= var_reg * multiplier;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bst_reg       <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            bst_reg <= bst_next;
            priority if (pop_pass) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= job_data[S-1:0];
                out_rep_reg   <= 1'b0;
                out_eop_reg   <= job_data[7*S+1];
            end else if (res_load) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_data;
                out_rep_reg   <= res_rep;
                out_eop_reg   <= 1'b0;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_rep_not_eop: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rep_reg) |-> !out_eop_reg)
        else $error("replaced sample flagged as end of pulse");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> bst_reg == B_IDLE)
        else $error("job taken while the back end was busy");
    a_sq_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (bst_reg == B_SQ && cnt_reg == 3'd7) |=> bst_reg == B_MUL)
        else $error("squaring pass did not finish in eight steps");

endmodule
